### sv/sgm_pkg.sv
// Shared constants, types and helpers of the Sobel gradient magnitude block.
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SIZE_MIN   = 3;

  localparam int PIX_W    = 8;
  localparam int COORD_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WSUM_W   = PIX_W + 2;
  localparam int GRAD_W   = WSUM_W + 1;
  localparam int ABS_W    = WSUM_W;
  localparam int SQ_W     = 2 * ABS_W;
  localparam int ENERGY_W = 16;
  localparam int ROOT_W   = ENERGY_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int ROOT_CELLS = ROOT_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

  // One column of the 3x3 window, top row first
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

  // One line memory word: the two rows above the current one
  typedef struct packed {
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;
  } line_pair_t;

  // Beat leaving the fetch stage
  typedef struct packed {
    pix_col_t column;
    logic     emit;
    coord_t   pos;
  } fetch_t;

  // Digit-by-digit square root state handed from cell to cell
  typedef struct packed {
    coord_t              pos;
    logic [ENERGY_W-1:0] rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
  } root_step_t;

  // Weighted sum a + 2b + c of three pixels
  function automatic logic [WSUM_W-1:0] weight3(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

endpackage

### sv/sgm_window_cell.sv
// One column cell of the 3x3 window: holds a pixel column and its weighted sum.
module sgm_window_cell (
  input  logic                          clk,
  input  logic                          shift,
  input  sgm_pkg::pix_col_t             in_col,
  output sgm_pkg::pix_col_t             out_col,
  output logic [sgm_pkg::WSUM_W-1:0]    col_sum
);
  import sgm_pkg::*;

  // Take the neighbor's column when the window advances
  always_ff @(posedge clk) begin
    if (shift) begin
      out_col <= in_col;
    end
  end

  // Vertical weighting of the held column
  assign col_sum = weight3(out_col.top, out_col.mid, out_col.bot);

endmodule

### sv/sgm_root_cell.sv
// One square root cell: settles one result bit per cell, two radicand bits in.
module sgm_root_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                in_valid,
  input  sgm_pkg::root_step_t in_step,
  output logic                out_valid,
  output sgm_pkg::root_step_t out_step
);
  import sgm_pkg::*;

  logic [REM_W+1:0] rem_shift;
  logic [REM_W+1:0] trial;
  root_step_t       step_next;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_shift     = {in_step.rem, in_step.rad[ENERGY_W-1 -: 2]};
    trial         = {2'b00, in_step.root, 2'b01};
    step_next.pos = in_step.pos;
    step_next.rad = {in_step.rad[ENERGY_W-3:0], 2'b00};
    if (rem_shift >= trial) begin
      step_next.rem  = REM_W'(rem_shift - trial);
      step_next.root = {in_step.root[ROOT_W-2:0], 1'b1};
    end else begin
      step_next.rem  = rem_shift[REM_W-1:0];
      step_next.root = {in_step.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Hold the beat unless the next cell can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_step <= step_next;
    end
  end

endmodule

### sv/sgm_front.sv
// Front end: size registers, raster counters, line memory and fetch stage.
module sgm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sgm_pkg::SIZE_W-1:0]        cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  logic [sgm_pkg::PIX_W-1:0]         pixel,
  input  logic                              take,
  output logic                              f_valid,
  output sgm_pkg::fetch_t                   f_data
);
  import sgm_pkg::*;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [SIZE_W-1:0] width_used;
  logic [SIZE_W-1:0] height_used;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              ready;
  logic              accept;
  logic              move;

  logic [PIX_W-1:0]  f_pix;
  logic [COL_W-1:0]  f_addr;
  logic              f_emit;
  coord_t            f_pos;
  line_pair_t        rd;
  line_pair_t        line_mem [MAX_WIDTH];

  // Clamp the programmed sizes to the supported range
  always_comb begin
    if (width_reg < SIZE_W'(SIZE_MIN)) begin
      width_used = SIZE_W'(SIZE_MIN);
    end else if (width_reg > SIZE_W'(MAX_WIDTH)) begin
      width_used = SIZE_W'(MAX_WIDTH);
    end else begin
      width_used = width_reg;
    end
    if (height_reg < SIZE_W'(SIZE_MIN)) begin
      height_used = SIZE_W'(SIZE_MIN);
    end else if (height_reg > SIZE_W'(MAX_HEIGHT)) begin
      height_used = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_used = height_reg;
    end
  end

  assign ready       = !f_valid || take;
  assign pixel_stall = !ready;
  assign accept      = pixel_valid && ready;
  assign move        = f_valid && take;
  assign col_inc     = SIZE_W'(col) + SIZE_W'(1);
  assign row_inc     = SIZE_W'(row) + SIZE_W'(1);

  // Size registers; a write restarts the frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the raster position on each accepted beat unless a size write restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_write &&
                 (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_inc >= width_used) begin
        col <= '0;
        if (row_inc >= height_used) begin
          row <= '0;
        end else begin
          row <= row_inc[ROW_W-1:0];
        end
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  // Fetch stage: hold the beat while its line word is read
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ready) begin
      f_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pix   <= pixel;
      f_addr  <= col;
      f_emit  <= (col >= COL_W'(2)) && (row >= ROW_W'(2));
      f_pos.x <= COORD_W'(col - COL_W'(1));
      f_pos.y <= COORD_W'(row - ROW_W'(1));
    end
  end

  // Line memory: read on accept, push the column down one row on move
  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= line_mem[col];
    end
    if (move) begin
      line_mem[f_addr] <= '{two_above: rd.above, above: f_pix};
    end
  end

  assign f_data.column = '{top: rd.two_above, mid: rd.above, bot: f_pix};
  assign f_data.emit   = f_emit;
  assign f_data.pos    = f_pos;

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(col) < width_used)
    else $error("column counter past the row width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    SIZE_W'(row) < height_used)
    else $error("row counter past the frame height");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> f_valid)
    else $error("input stalled with an empty fetch stage");

endmodule

### sv/sobel_gradient_magnitude.sv
// Top level: 3x3 Sobel gradient magnitude over a raster pixel stream.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   pixel    | pixel_valid / pixel_stall  | pixel
//   result   | result_valid / result_stall| center_x, center_y, magnitude
//   config   | cfg_write                  | cfg_index, cfg_data
//
// One pixel is taken per cycle while pixel_stall is low; each beat passes
// from input to result through fetch (line memory read), window, gradient,
// squares, energy and eight square root cells, one result bit per cell.
// Stalls back up stage by stage; empty stages fill, so input keeps flowing
// while a result waits. Reset (rst, synchronous) clears valids, counters
// and sizes (512 x 512); the line memory needs no clearing.
module sobel_gradient_magnitude (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sgm_pkg::SIZE_W-1:0]       cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [sgm_pkg::PIX_W-1:0]        pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [sgm_pkg::COORD_W-1:0]      center_x,
  output logic [sgm_pkg::COORD_W-1:0]      center_y,
  output logic [sgm_pkg::ROOT_W-1:0]       magnitude
);
  import sgm_pkg::*;

  logic              f_valid;
  fetch_t            f_data;

  logic              g_valid;
  logic              g_load;
  coord_t            g_pos;
  pix_col_t          wcol [3];
  logic [WSUM_W-1:0] wsum [3];

  logic                     h_valid;
  logic                     h_load;
  coord_t                   h_pos;
  logic signed [GRAD_W-1:0] h_gx;
  logic signed [GRAD_W-1:0] h_gy;
  logic signed [GRAD_W-1:0] gx_c;
  logic signed [GRAD_W-1:0] gy_c;

  logic             m_valid;
  logic             m_load;
  coord_t           m_pos;
  logic [SQ_W-1:0]  m_sqx;
  logic [SQ_W-1:0]  m_sqy;
  logic [ABS_W-1:0] ax;
  logic [ABS_W-1:0] ay;

  logic            e_load;
  logic [SQ_W:0]   energy;

  logic [ROOT_CELLS:0] chain_valid;
  logic [ROOT_CELLS:0] chain_ready;
  root_step_t          chain_step [ROOT_CELLS+1];

  // Ready chain, back from the output register
  always_comb begin
    chain_ready[ROOT_CELLS] = !result_stall;
    for (int i = ROOT_CELLS - 1; i >= 0; i--) begin
      chain_ready[i] = !chain_valid[i+1] || chain_ready[i+1];
    end
  end

  assign e_load = !chain_valid[0] || chain_ready[0];
  assign m_load = !m_valid || e_load;
  assign h_load = !h_valid || m_load;
  assign g_load = !g_valid || h_load;

  sgm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .take        (g_load),
    .f_valid     (f_valid),
    .f_data      (f_data)
  );

  // Window: three column cells, newest on the right
  sgm_window_cell u_wcell2 (
    .clk(clk), .shift(f_valid && g_load), .in_col(f_data.column),
    .out_col(wcol[2]), .col_sum(wsum[2])
  );
  sgm_window_cell u_wcell1 (
    .clk(clk), .shift(f_valid && g_load), .in_col(wcol[2]),
    .out_col(wcol[1]), .col_sum(wsum[1])
  );
  sgm_window_cell u_wcell0 (
    .clk(clk), .shift(f_valid && g_load), .in_col(wcol[1]),
    .out_col(wcol[0]), .col_sum(wsum[0])
  );

  // Window stage tags: only interior centres go on
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (g_load) begin
      g_valid <= f_valid && f_data.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (g_load) begin
      g_pos <= f_data.pos;
    end
  end

  // Sobel sums
  always_comb begin
    gx_c = GRAD_W'({1'b0, wsum[2]}) - GRAD_W'({1'b0, wsum[0]});
    gy_c = GRAD_W'({1'b0, weight3(wcol[0].bot, wcol[1].bot, wcol[2].bot)})
         - GRAD_W'({1'b0, weight3(wcol[0].top, wcol[1].top, wcol[2].top)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (h_load) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (h_load) begin
      h_pos <= g_pos;
      h_gx  <= gx_c;
      h_gy  <= gy_c;
    end
  end

  // Square the magnitudes
  assign ax = h_gx[GRAD_W-1] ? ABS_W'(-h_gx) : ABS_W'(h_gx);
  assign ay = h_gy[GRAD_W-1] ? ABS_W'(-h_gy) : ABS_W'(h_gy);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_load) begin
      m_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_pos <= h_pos;
      m_sqx <= SQ_W'(ax) * SQ_W'(ax);
      m_sqy <= SQ_W'(ay) * SQ_W'(ay);
    end
  end

  // Energy, saturated to the square root range (root of all ones is 255)
  assign energy = {1'b0, m_sqx} + {1'b0, m_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (e_load) begin
      chain_valid[0] <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      chain_step[0].pos  <= m_pos;
      chain_step[0].rad  <= (energy[SQ_W:ENERGY_W] != '0) ? '1 : energy[ENERGY_W-1:0];
      chain_step[0].rem  <= '0;
      chain_step[0].root <= '0;
    end
  end

  // Square root cells, one result bit each
  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_root
    sgm_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (chain_ready[i]),
      .in_valid  (chain_valid[i]),
      .in_step   (chain_step[i]),
      .out_valid (chain_valid[i+1]),
      .out_step  (chain_step[i+1])
    );
  end

  assign result_valid = chain_valid[ROOT_CELLS];
  assign center_x     = chain_step[ROOT_CELLS].pos.x;
  assign center_y     = chain_step[ROOT_CELLS].pos.y;
  assign magnitude    = chain_step[ROOT_CELLS].root;

  a_interior: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (center_x != '0) && (center_y != '0))
    else $error("result for a border centre");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, chain_step[ROOT_CELLS].rem} <= {1'b0, magnitude, 1'b0}))
    else $error("square root remainder out of range");

  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    h_valid |-> (h_gx >= -GRAD_W'(1020)) && (h_gx <= GRAD_W'(1020)) &&
                (h_gy >= -GRAD_W'(1020)) && (h_gy <= GRAD_W'(1020)))
    else $error("Sobel sum out of range");

endmodule
